[hw/rtl/audio_loop_recorder_assert.svh]
// Assertion macros shared by the loop recorder RTL.
`ifndef AUDIO_LOOP_RECORDER_ASSERT_SVH
`define AUDIO_LOOP_RECORDER_ASSERT_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define ALR_ASSERT_IMPLY(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("loop recorder check failed");

// Whenever the condition holds, the consequence must hold in the next cycle.
`define ALR_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("loop recorder check failed");

`endif

[hw/rtl/alr_pkg.sv]
package alr_pkg;

    localparam int unsigned LOOP_DEPTH_DEF   = 65536;
    localparam int unsigned SAMPLE_WIDTH_DEF = 16;

    // What the second stage does with an item.
    typedef enum logic [2:0] {
        OP_SILENT,   // empty loop, output zero
        OP_PASS,     // recording with a full buffer, pass through only
        OP_RECORD,   // pass through and store
        OP_PLAY,     // output the stored sample
        OP_DUB       // output and store the saturated sum
    } t_s1_op;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

[hw/rtl/audio_loop_recorder.sv]
// Audio loop recorder: takes one sample item per cycle and returns one result
// item per accepted item via the second stage and output register; the input
// is stalled only while a result waits at the output and the second stage is
// also full. All loop audio lives in a single LOOP_DEPTH-entry memory with one
// read and one write port; the read is issued when an item is accepted, and
// the write (record or overdub sum) happens when the item leaves the second
// stage, with a bypass when the next item reads that same entry. Playback
// only reads entries written since the loop was last emptied, so the memory
// needs no clearing after reset.
module audio_loop_recorder
    import alr_pkg::*;
#(
    parameter int unsigned LOOP_DEPTH   = LOOP_DEPTH_DEF,
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_trigger_high,
    input  logic                           i_overdub_high,
    input  logic                           i_clear_high,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_rec_lamp,
    output logic                           o_play_lamp
);

    localparam int unsigned ADDR_W = $clog2(LOOP_DEPTH);
    localparam int unsigned LEN_W  = $clog2(LOOP_DEPTH + 1);

    // Loop control state.
    logic [LEN_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic              r_recording, n_recording;
    logic              r_armed, n_armed;
    logic              r_dub_active, n_dub_active;
    logic              r_trig_prev, r_dub_prev;

    // Second stage.
    logic                           r_s1_valid;
    t_s1_op                         r_s1_op, n_s1_op;
    logic [ADDR_W-1:0]              r_s1_addr, n_s1_addr;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_x;
    logic                           r_s1_rec_lamp, r_s1_play_lamp;

    // Output register.
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_rec_lamp, r_out_play_lamp;

    logic                           accept, s1_adv;
    t_mem_ctl                       mem_ctl;
    logic [SAMPLE_WIDTH-1:0]        mem_rd_data;
    logic signed [SAMPLE_WIDTH-1:0] stored;
    logic signed [SAMPLE_WIDTH:0]   dub_sum;
    logic signed [SAMPLE_WIDTH-1:0] dub_sat;
    logic signed [SAMPLE_WIDTH-1:0] s1_y;
    logic [SAMPLE_WIDTH-1:0]        wr_data;
    logic [LEN_W-1:0]               pos_inc;

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    // Control update for the item at the input: trigger, overdub, clear,
    // then either record or play.
    always_comb begin
        n_len        = r_len;
        n_pos        = r_pos;
        n_recording  = r_recording;
        n_armed      = r_armed;
        n_dub_active = r_dub_active;
        n_s1_op      = OP_SILENT;
        n_s1_addr    = r_pos;
        pos_inc      = LEN_W'(r_pos) + LEN_W'(1);

        if (i_trigger_high && !r_trig_prev) begin
            if (!r_recording) begin
                n_len        = '0;
                n_pos        = '0;
                n_armed      = 1'b0;
                n_dub_active = 1'b0;
            end else begin
                n_armed = 1'b1;
            end
            n_recording = !r_recording;
        end

        if (i_overdub_high && !r_dub_prev && n_armed) begin
            n_dub_active = !n_dub_active;
        end

        if (i_clear_high) begin
            n_armed      = 1'b0;
            n_recording  = 1'b0;
            n_dub_active = 1'b0;
            n_len        = '0;
            n_pos        = '0;
        end

        pos_inc = LEN_W'(n_pos) + LEN_W'(1);
        if (n_recording) begin
            if (n_len < LEN_W'(LOOP_DEPTH)) begin
                n_s1_op   = OP_RECORD;
                n_s1_addr = n_len[ADDR_W-1:0];
                n_len     = n_len + LEN_W'(1);
            end else begin
                n_s1_op = OP_PASS;
            end
        end else begin
            if (n_len != '0) begin
                n_s1_op   = n_dub_active ? OP_DUB : OP_PLAY;
                n_s1_addr = n_pos;
            end
            n_pos = (pos_inc >= n_len) ? '0 : pos_inc[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_pos        <= '0;
            r_recording  <= 1'b0;
            r_armed      <= 1'b0;
            r_dub_active <= 1'b0;
            r_trig_prev  <= 1'b0;
            r_dub_prev   <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_len        <= n_len;
                r_pos        <= n_pos;
                r_recording  <= n_recording;
                r_armed      <= n_armed;
                r_dub_active <= n_dub_active;
                r_trig_prev  <= i_trigger_high;
                r_dub_prev   <= i_overdub_high;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op        <= n_s1_op;
            r_s1_addr      <= n_s1_addr;
            r_s1_x         <= i_sample_in;
            r_s1_rec_lamp  <= n_recording || n_dub_active;
            r_s1_play_lamp <= n_armed;
        end
        if (s1_adv) begin
            r_out_sample    <= s1_y;
            r_out_rec_lamp  <= r_s1_rec_lamp;
            r_out_play_lamp <= r_s1_play_lamp;
        end
    end

    assign mem_ctl.rd_en = accept;
    assign mem_ctl.wr_en = s1_adv && ((r_s1_op == OP_RECORD) || (r_s1_op == OP_DUB));

    alr_loop_mem #(
        .LOOP_DEPTH   (LOOP_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_loop_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (n_s1_addr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data),
        .o_rd_data (mem_rd_data)
    );

    // Saturating overdub: the sum overflowed when its top two bits differ.
    always_comb begin
        stored  = $signed(mem_rd_data);
        dub_sum = {stored[SAMPLE_WIDTH-1], stored} + {r_s1_x[SAMPLE_WIDTH-1], r_s1_x};
        if (dub_sum[SAMPLE_WIDTH] != dub_sum[SAMPLE_WIDTH-1]) begin
            dub_sat = {dub_sum[SAMPLE_WIDTH], {(SAMPLE_WIDTH-1){!dub_sum[SAMPLE_WIDTH]}}};
        end else begin
            dub_sat = dub_sum[SAMPLE_WIDTH-1:0];
        end
        unique case (r_s1_op)
            OP_SILENT: s1_y = '0;
            OP_PASS:   s1_y = r_s1_x;
            OP_RECORD: s1_y = r_s1_x;
            OP_PLAY:   s1_y = stored;
            OP_DUB:    s1_y = dub_sat;
            default:   s1_y = '0;
        endcase
        wr_data = (r_s1_op == OP_RECORD) ? r_s1_x : dub_sat;
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_rec_lamp   = r_out_rec_lamp;
    assign o_play_lamp  = r_out_play_lamp;

`include "audio_loop_recorder_assert.svh"

    `ALR_ASSERT_IMPLY(a_rec_not_armed, r_recording, !r_armed)
    `ALR_ASSERT_IMPLY(a_dub_needs_armed, r_dub_active, r_armed)
    `ALR_ASSERT_IMPLY(a_pos_in_loop, r_len != '0, LEN_W'(r_pos) < r_len)
    `ALR_ASSERT_IMPLY(a_write_leaves_s1, mem_ctl.wr_en, r_s1_valid && s1_adv)
    `ALR_ASSERT_NEXT(a_s1_moves_out, s1_adv, r_out_valid)

endmodule

[hw/rtl/alr_loop_mem.sv]
module alr_loop_mem
    import alr_pkg::*;
#(
    parameter int unsigned LOOP_DEPTH   = LOOP_DEPTH_DEF,
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int unsigned ADDR_W      = $clog2(LOOP_DEPTH)
) (
    input  logic                    i_clk,
    input  t_mem_ctl                i_ctl,
    input  logic [ADDR_W-1:0]       i_rd_addr,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  logic [SAMPLE_WIDTH-1:0] i_wr_data,
    output logic [SAMPLE_WIDTH-1:0] o_rd_data
);

    logic [SAMPLE_WIDTH-1:0] r_mem [LOOP_DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_ram_q;
    logic [SAMPLE_WIDTH-1:0] r_fwd_data;
    logic                    r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The array reads the old contents when both ports hit one entry in the
    // same cycle, so the written value is captured beside it and muxed in.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_ram_q    <= r_mem[i_rd_addr];
            r_fwd      <= i_ctl.wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_ram_q;

endmodule
